/* src/cpps_pkg.sv */
// cpps_pkg: shared types, codes and constants of the cart-pole step block.
// Holds the microprogram of the step sequence and the sine/cosine table
// builder. Depends on nothing.
package cpps_pkg;

    typedef logic signed [31:0] word_t;

    localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint Q30_ONE = 64'sd1073741824;

    typedef enum logic [2:0] {
        CFG_PUSH_FORCE,
        CFG_TIME_STEP,
        CFG_GRAVITY,
        CFG_POLE_MASS,
        CFG_CART_MASS,
        CFG_HALF_LEN,
        CFG_POS_LIMIT,
        CFG_ANG_LIMIT
    } cfg_idx_t;

    localparam int CFG_COUNT = 8;
    localparam logic [30:0] CFG_RESET [CFG_COUNT] = '{
        31'd655360, 31'd1311, 31'd642253, 31'd6554,
        31'd65536, 31'd32768, 31'd157286, 31'd13726
    };

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL,
        OP_FMUL_WB,
        OP_ADD,
        OP_SUB,
        OP_DIV,
        OP_ANG_IDX,
        OP_SC_WB,
        OP_LOAD,
        OP_FIN_STEP,
        OP_FIN_LOAD
    } op_t;

    typedef enum logic [4:0] {
        SRC_ZERO,
        SRC_X,
        SRC_V,
        SRC_A,
        SRC_W,
        SRC_S,
        SRC_C,
        SRC_TOT,
        SRC_PML,
        SRC_TEMP,
        SRC_DEN,
        SRC_TACC,
        SRC_XACC,
        SRC_T1,
        SRC_T2,
        SRC_FORCE,
        SRC_TAU,
        SRC_G,
        SRC_MP,
        SRC_MC,
        SRC_HL,
        SRC_FT,
        SRC_INV2PI
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_X,
        DST_V,
        DST_A,
        DST_W,
        DST_TOT,
        DST_PML,
        DST_TEMP,
        DST_DEN,
        DST_TACC,
        DST_XACC,
        DST_T1,
        DST_T2
    } dst_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        dst_t dst;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } status_t;

    typedef logic [5:0] pc_t;
    localparam pc_t LOAD_PC = 6'd48;

    function automatic word_t sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic cmd_t mk(input op_t op, input src_t a, input src_t b, input dst_t dst);
        cmd_t c;
        c.op = op;
        c.a = a;
        c.b = b;
        c.dst = dst;
        return c;
    endfunction

    // step sequence; a product takes a MUL and a write-back slot
    function automatic cmd_t ucode(input pc_t pc);
        case (pc)
            6'd0:  return mk(OP_MUL, SRC_A, SRC_INV2PI, DST_NONE);
            6'd1:  return mk(OP_ANG_IDX, SRC_ZERO, SRC_ZERO, DST_NONE);
            6'd2:  return mk(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE);
            6'd3:  return mk(OP_SC_WB, SRC_ZERO, SRC_ZERO, DST_NONE);
            6'd4:  return mk(OP_ADD, SRC_MP, SRC_MC, DST_TOT);
            6'd5:  return mk(OP_MUL, SRC_MP, SRC_HL, DST_NONE);
            6'd6:  return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_PML);
            6'd7:  return mk(OP_MUL, SRC_PML, SRC_W, DST_NONE);
            6'd8:  return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd9:  return mk(OP_MUL, SRC_T1, SRC_W, DST_NONE);
            6'd10: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd11: return mk(OP_MUL, SRC_T1, SRC_S, DST_NONE);
            6'd12: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd13: return mk(OP_ADD, SRC_FORCE, SRC_T1, DST_T1);
            6'd14: return mk(OP_DIV, SRC_T1, SRC_TOT, DST_TEMP);
            6'd15: return mk(OP_MUL, SRC_MP, SRC_C, DST_NONE);
            6'd16: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd17: return mk(OP_MUL, SRC_T1, SRC_C, DST_NONE);
            6'd18: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd19: return mk(OP_DIV, SRC_T1, SRC_TOT, DST_T1);
            6'd20: return mk(OP_SUB, SRC_FT, SRC_T1, DST_T1);
            6'd21: return mk(OP_MUL, SRC_HL, SRC_T1, DST_NONE);
            6'd22: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_DEN);
            6'd23: return mk(OP_MUL, SRC_G, SRC_S, DST_NONE);
            6'd24: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd25: return mk(OP_MUL, SRC_C, SRC_TEMP, DST_NONE);
            6'd26: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T2);
            6'd27: return mk(OP_SUB, SRC_T1, SRC_T2, DST_T1);
            6'd28: return mk(OP_DIV, SRC_T1, SRC_DEN, DST_TACC);
            6'd29: return mk(OP_MUL, SRC_PML, SRC_TACC, DST_NONE);
            6'd30: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd31: return mk(OP_MUL, SRC_T1, SRC_C, DST_NONE);
            6'd32: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd33: return mk(OP_DIV, SRC_T1, SRC_TOT, DST_T1);
            6'd34: return mk(OP_SUB, SRC_TEMP, SRC_T1, DST_XACC);
            // Euler update: position before velocity, angle before rate
            6'd35: return mk(OP_MUL, SRC_TAU, SRC_V, DST_NONE);
            6'd36: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd37: return mk(OP_ADD, SRC_X, SRC_T1, DST_X);
            6'd38: return mk(OP_MUL, SRC_TAU, SRC_XACC, DST_NONE);
            6'd39: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd40: return mk(OP_ADD, SRC_V, SRC_T1, DST_V);
            6'd41: return mk(OP_MUL, SRC_TAU, SRC_W, DST_NONE);
            6'd42: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd43: return mk(OP_ADD, SRC_A, SRC_T1, DST_A);
            6'd44: return mk(OP_MUL, SRC_TAU, SRC_TACC, DST_NONE);
            6'd45: return mk(OP_FMUL_WB, SRC_ZERO, SRC_ZERO, DST_T1);
            6'd46: return mk(OP_ADD, SRC_W, SRC_T1, DST_W);
            6'd47: return mk(OP_FIN_STEP, SRC_ZERO, SRC_ZERO, DST_NONE);
            6'd48: return mk(OP_LOAD, SRC_ZERO, SRC_ZERO, DST_NONE);
            6'd49: return mk(OP_FIN_LOAD, SRC_ZERO, SRC_ZERO, DST_NONE);
            default: return mk(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE);
        endcase
    endfunction

    // Q30 product rounded half up
    function automatic longint unsigned q30_sq(input longint unsigned a,
                                               input longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // one quarter-turn table entry: Q30 Taylor series rounded to f fraction bits
    function automatic logic [31:0] trig_entry(input int unsigned k, input int unsigned atb,
                                               input int unsigned f, input bit want_cos);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint sa;
        longint ca;
        longint v;
        longint unsigned r;
        x = (longint'(k) * HALF_PI_Q30) >> atb;
        x2 = q30_sq(x, x);
        // each term from the last, divided by the next two factorial factors
        t = x;
        sa = longint'(x);
        t = q30_sq(t, x2) / 64'd6;   sa = sa - longint'(t);
        t = q30_sq(t, x2) / 64'd20;  sa = sa + longint'(t);
        t = q30_sq(t, x2) / 64'd42;  sa = sa - longint'(t);
        t = q30_sq(t, x2) / 64'd72;  sa = sa + longint'(t);
        t = q30_sq(t, x2) / 64'd110; sa = sa - longint'(t);
        t = q30_sq(t, x2) / 64'd156; sa = sa + longint'(t);
        t = 64'(Q30_ONE);
        ca = Q30_ONE;
        t = q30_sq(t, x2) / 64'd2;   ca = ca - longint'(t);
        t = q30_sq(t, x2) / 64'd12;  ca = ca + longint'(t);
        t = q30_sq(t, x2) / 64'd30;  ca = ca - longint'(t);
        t = q30_sq(t, x2) / 64'd56;  ca = ca + longint'(t);
        t = q30_sq(t, x2) / 64'd90;  ca = ca - longint'(t);
        t = q30_sq(t, x2) / 64'd132; ca = ca + longint'(t);
        t = q30_sq(t, x2) / 64'd182; ca = ca - longint'(t);
        v = want_cos ? ca : sa;
        if (v < 0)
            v = 0;
        if (v > Q30_ONE)
            v = Q30_ONE;
        r = (64'(v) + (64'd1 << (29 - f))) >> (30 - f);
        return r[31:0];
    endfunction

endpackage

/* src/cpps_ifs.sv */
// Channel interfaces of the cart-pole step block: request in, result out,
// register write. Depends on nothing.
interface cpps_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic        push_right;
    logic [31:0] load_position;
    logic [31:0] load_velocity;
    logic [31:0] load_angle;
    logic [31:0] load_angular_rate;

    modport source (output valid, opcode, push_right, load_position, load_velocity,
                    load_angle, load_angular_rate, input ready);
    modport sink (input valid, opcode, push_right, load_position, load_velocity,
                  load_angle, load_angular_rate, output ready);
endinterface

interface cpps_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] cart_position;
    logic [31:0] cart_velocity;
    logic [31:0] pole_angle;
    logic [31:0] pole_angular_rate;
    logic        reward;
    logic        terminated;
    logic        truncated;
    logic        after_fall;

    modport source (output valid, cart_position, cart_velocity, pole_angle,
                    pole_angular_rate, reward, terminated, truncated, after_fall,
                    input ready);
    modport sink (input valid, cart_position, cart_velocity, pole_angle,
                  pole_angular_rate, reward, terminated, truncated, after_fall,
                  output ready);
endinterface

interface cpps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [30:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/cart_pole_physics_step.sv */
// cart_pole_physics_step: top level; joins the sequencer and the datapath.
// Depends on cpps_pkg, cpps_ifs, cpps_ctrl, cpps_dp.
//
//  channel  | direction | carries
//  in_ch    | sink      | opcode, push_right, load_position/velocity/angle/angular_rate
//  out_ch   | source    | new state, reward, terminated, truncated, after_fall
//  cfg_ch   | sink      | index (register number), data (31 bits); always ready
//
// A load request copies the load values into the state, then registers the
// new state as the result. A step request runs the microcode slots of the
// step sequence, four of them divisions that each produce FRACTION_BITS + 32
// quotient bits and then hand the quotient back. One request is in flight
// at a time; the input is ready again from the cycle after the result is
// written, and a result not yet taken holds the sequence at its write-back.
// Reset sets the registers to their defaults and the state to zero.
module cart_pole_physics_step
    import cpps_pkg::*;
#(
    parameter int MAX_EPISODE_STEPS = 500,
    parameter int FRACTION_BITS = 16,
    parameter int ANGLE_TABLE_BITS = 10
) (
    input logic       clk,
    input logic       rst_n,
    cpps_in_if.sink   in_ch,
    cpps_out_if.source out_ch,
    cpps_cfg_if.sink  cfg_ch
);

    cmd_t    cmd;
    status_t status;
    logic    take;
    logic    in_ready;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready = in_ready;

    cpps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ready),
        .take      (take),
        .cmd       (cmd),
        .status    (status)
    );

    cpps_dp #(
        .MAX_EPISODE_STEPS(MAX_EPISODE_STEPS),
        .FRACTION_BITS(FRACTION_BITS),
        .ANGLE_TABLE_BITS(ANGLE_TABLE_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .take              (take),
        .push_right        (in_ch.push_right),
        .load_position     (in_ch.load_position),
        .load_velocity     (in_ch.load_velocity),
        .load_angle        (in_ch.load_angle),
        .load_angular_rate (in_ch.load_angular_rate),
        .cfg_we            (cfg_ch.valid),
        .cfg_index         (cfg_ch.index),
        .cfg_data          (cfg_ch.data),
        .out_ready         (out_ch.ready),
        .out_valid         (out_ch.valid),
        .cart_position     (out_ch.cart_position),
        .cart_velocity     (out_ch.cart_velocity),
        .pole_angle        (out_ch.pole_angle),
        .pole_angular_rate (out_ch.pole_angular_rate),
        .reward            (out_ch.reward),
        .terminated        (out_ch.terminated),
        .truncated         (out_ch.truncated),
        .after_fall        (out_ch.after_fall)
    );

endmodule

/* src/cpps_div.sv */
// cpps_div: signed fixed-point divider, (num << F) / den truncated toward zero,
// one quotient bit a cycle, saturating. Depends on cpps_pkg.
module cpps_div
    import cpps_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t num,
    input  word_t den,
    output logic  done,
    output word_t quo
);

    localparam int NW = 32 + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [32:0]   rem_reg;
    logic [31:0]   dmag_reg;
    logic          neg_reg;
    logic          dzero_reg;
    logic          nneg_reg;
    logic          nzero_reg;
    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    word_t         quo_out_reg;

    logic [32:0] shifted;
    logic [32:0] diff;
    word_t       result;
    logic [31:0] nmag;

    assign nmag = num[31] ? 32'(-num) : 32'(num);
    assign shifted = {rem_reg[31:0], quo_reg[NW-1]};
    assign diff = shifted - {1'b0, dmag_reg};

    always_comb
    begin
        if (dzero_reg)
            result = nzero_reg ? 32'sd0 : (nneg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        else if (!neg_reg)
            result = (quo_reg > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : quo_reg[31:0];
        else
            result = (quo_reg > NW'(32'h8000_0000)) ? 32'sh8000_0000 : -quo_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= (den == 32'sd0) ? '0 : CW'(NW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= {nmag, {FRACTION_BITS{1'b0}}};
            rem_reg <= '0;
            dmag_reg <= den[31] ? 32'(-den) : 32'(den);
            neg_reg <= num[31] ^ den[31];
            dzero_reg <= (den == 32'sd0);
            nneg_reg <= num[31];
            nzero_reg <= (num == 32'sd0);
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            // restoring step: shifted stays below 2^32, so bit 32 is the borrow
            if (!diff[32])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
        if (busy_reg && cnt_reg == '0)
            quo_out_reg <= result;
    end

    assign done = done_reg;
    assign quo = quo_out_reg;

endmodule

/* src/cpps_trig_rom.sv */
// cpps_trig_rom: quarter-turn sine and cosine table, built at elaboration,
// registered read. Depends on cpps_pkg.
module cpps_trig_rom
    import cpps_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int ANGLE_TABLE_BITS = 10
) (
    input  logic                        clk,
    input  logic [ANGLE_TABLE_BITS-1:0] idx,
    output logic [FRACTION_BITS:0]      sin_q,
    output logic [FRACTION_BITS:0]      cos_q
);

    localparam int N = 2 ** ANGLE_TABLE_BITS;

    logic [FRACTION_BITS:0] sin_tab [N];
    logic [FRACTION_BITS:0] cos_tab [N];

    for (genvar i = 0; i < N; i++)
    begin : g_tab
        assign sin_tab[i] = (FRACTION_BITS + 1)'(trig_entry(i, ANGLE_TABLE_BITS,
                                                            FRACTION_BITS, 1'b0));
        assign cos_tab[i] = (FRACTION_BITS + 1)'(trig_entry(i, ANGLE_TABLE_BITS,
                                                            FRACTION_BITS, 1'b1));
    end

    always_ff @(posedge clk)
    begin
        sin_q <= sin_tab[idx];
        cos_q <= cos_tab[idx];
    end

endmodule

/* src/cpps_ctrl.sv */
// cpps_ctrl: sequencer of the cart-pole step; walks the microprogram in
// cpps_pkg and issues one command a cycle unless idle or stalled. Depends on cpps_pkg.
module cpps_ctrl
    import cpps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_opcode,
    output logic    in_ready,
    output logic    take,
    output cmd_t    cmd,
    input  status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_WAIT
    } state_t;

    state_t state_reg;
    pc_t    pc_reg;
    logic   in_ready_reg;
    cmd_t   instr;
    logic   is_fin;
    logic   stall;

    assign instr = ucode(pc_reg);
    assign is_fin = (instr.op == OP_FIN_STEP) || (instr.op == OP_FIN_LOAD);
    // a result may only be written once the previous one has gone
    assign stall = is_fin && !status.out_free;
    assign take = in_valid && in_ready_reg;
    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd = mk(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE);
        if (state_reg == ST_EXEC && !stall)
            cmd = instr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        state_reg <= ST_EXEC;
                        in_ready_reg <= 1'b0;
                        pc_reg <= in_opcode ? LOAD_PC : '0;
                    end
                end
                ST_EXEC:
                begin
                    if (!stall)
                    begin
                        pc_reg <= pc_reg + 1'b1;
                        if (instr.op == OP_DIV)
                            state_reg <= ST_DIV_WAIT;
                        else if (is_fin)
                        begin
                            state_reg <= ST_IDLE;
                            in_ready_reg <= 1'b1;
                        end
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (status.div_done)
                        state_reg <= ST_EXEC;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* src/cpps_dp.sv */
// cpps_dp: datapath of the cart-pole step: state and working registers,
// shared multiplier, divider, trig table, result register.
// Depends on cpps_pkg, cpps_div, cpps_trig_rom.
module cpps_dp
    import cpps_pkg::*;
#(
    parameter int MAX_EPISODE_STEPS = 500,
    parameter int FRACTION_BITS = 16,
    parameter int ANGLE_TABLE_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        take,
    input  logic        push_right,
    input  logic [31:0] load_position,
    input  logic [31:0] load_velocity,
    input  logic [31:0] load_angle,
    input  logic [31:0] load_angular_rate,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [31:0] cart_position,
    output logic [31:0] cart_velocity,
    output logic [31:0] pole_angle,
    output logic [31:0] pole_angular_rate,
    output logic        reward,
    output logic        terminated,
    output logic        truncated,
    output logic        after_fall
);

    localparam int F = FRACTION_BITS;
    localparam int ATB = ANGLE_TABLE_BITS;
    localparam int SH = F + 30 - ATB;
    localparam logic signed [31:0] FOUR_THIRDS = 32'(((4 << F) + 1) / 3);
    localparam logic [15:0] STEP_CAP = 16'(MAX_EPISODE_STEPS);

    localparam logic [1:0] FALL_UPRIGHT = 2'd0;
    localparam logic [1:0] FALL_REPORTED = 2'd1;
    localparam logic [1:0] FALL_AFTER = 2'd2;

    logic [30:0] cfg_reg [CFG_COUNT];

    word_t x_reg, v_reg, a_reg, w_reg;
    word_t s_reg, c_reg, tot_reg, pml_reg, temp_reg, den_reg, tacc_reg, xacc_reg;
    word_t t1_reg, t2_reg;
    logic  push_reg;
    word_t ld_x_reg, ld_v_reg, ld_a_reg, ld_w_reg;
    logic signed [63:0] prod_reg;
    logic [ATB+1:0]     idx_reg;
    dst_t               div_dst_reg;
    logic [15:0]        count_reg;
    logic [1:0]         fall_reg;

    logic   out_valid_reg;
    word_t  out_x_reg, out_v_reg, out_a_reg, out_w_reg;
    logic   out_reward_reg, out_term_reg, out_trunc_reg, out_after_reg;

    word_t opa, opb, force_val, fmul_res, div_q, wr_data;
    dst_t  wr_dst;
    logic  div_done;
    logic [63:0] ang_sum;
    logic [F:0]  sin_q, cos_q;
    word_t smag, cmag;
    logic signed [63:0] rnd;
    logic [15:0] count_next;
    logic  term;
    word_t xl, al;

    assign force_val = push_reg ? $signed({1'b0, cfg_reg[CFG_PUSH_FORCE]})
                                : -$signed({1'b0, cfg_reg[CFG_PUSH_FORCE]});

    always_comb
    begin
        case (cmd.a)
            SRC_X:      opa = x_reg;
            SRC_V:      opa = v_reg;
            SRC_A:      opa = a_reg;
            SRC_W:      opa = w_reg;
            SRC_S:      opa = s_reg;
            SRC_C:      opa = c_reg;
            SRC_TOT:    opa = tot_reg;
            SRC_PML:    opa = pml_reg;
            SRC_TEMP:   opa = temp_reg;
            SRC_DEN:    opa = den_reg;
            SRC_TACC:   opa = tacc_reg;
            SRC_XACC:   opa = xacc_reg;
            SRC_T1:     opa = t1_reg;
            SRC_T2:     opa = t2_reg;
            SRC_FORCE:  opa = force_val;
            SRC_TAU:    opa = $signed({1'b0, cfg_reg[CFG_TIME_STEP]});
            SRC_G:      opa = $signed({1'b0, cfg_reg[CFG_GRAVITY]});
            SRC_MP:     opa = $signed({1'b0, cfg_reg[CFG_POLE_MASS]});
            SRC_MC:     opa = $signed({1'b0, cfg_reg[CFG_CART_MASS]});
            SRC_HL:     opa = $signed({1'b0, cfg_reg[CFG_HALF_LEN]});
            SRC_FT:     opa = FOUR_THIRDS;
            SRC_INV2PI: opa = INV_TWO_PI_Q32;
            default:    opa = 32'sd0;
        endcase
    end

    always_comb
    begin
        case (cmd.b)
            SRC_X:      opb = x_reg;
            SRC_V:      opb = v_reg;
            SRC_A:      opb = a_reg;
            SRC_W:      opb = w_reg;
            SRC_S:      opb = s_reg;
            SRC_C:      opb = c_reg;
            SRC_TOT:    opb = tot_reg;
            SRC_PML:    opb = pml_reg;
            SRC_TEMP:   opb = temp_reg;
            SRC_DEN:    opb = den_reg;
            SRC_TACC:   opb = tacc_reg;
            SRC_XACC:   opb = xacc_reg;
            SRC_T1:     opb = t1_reg;
            SRC_T2:     opb = t2_reg;
            SRC_FORCE:  opb = force_val;
            SRC_TAU:    opb = $signed({1'b0, cfg_reg[CFG_TIME_STEP]});
            SRC_G:      opb = $signed({1'b0, cfg_reg[CFG_GRAVITY]});
            SRC_MP:     opb = $signed({1'b0, cfg_reg[CFG_POLE_MASS]});
            SRC_MC:     opb = $signed({1'b0, cfg_reg[CFG_CART_MASS]});
            SRC_HL:     opb = $signed({1'b0, cfg_reg[CFG_HALF_LEN]});
            SRC_FT:     opb = FOUR_THIRDS;
            SRC_INV2PI: opb = INV_TWO_PI_Q32;
            default:    opb = 32'sd0;
        endcase
    end

    // product rounded half up, arithmetic shift gives the floor
    assign rnd = prod_reg + (64'sd1 <<< (F - 1));
    assign fmul_res = sat64(rnd >>> F);

    assign ang_sum = 64'(prod_reg) + (64'd1 << (SH - 1));

    cpps_div #(
        .FRACTION_BITS(F)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV),
        .num   (opa),
        .den   (opb),
        .done  (div_done),
        .quo   (div_q)
    );

    cpps_trig_rom #(
        .FRACTION_BITS(F),
        .ANGLE_TABLE_BITS(ATB)
    ) u_rom (
        .clk   (clk),
        .idx   (idx_reg[ATB-1:0]),
        .sin_q (sin_q),
        .cos_q (cos_q)
    );

    assign smag = $signed(32'(sin_q));
    assign cmag = $signed(32'(cos_q));

    always_comb
    begin
        wr_dst = DST_NONE;
        wr_data = fmul_res;
        if (div_done)
        begin
            wr_dst = div_dst_reg;
            wr_data = div_q;
        end
        else
        begin
            case (cmd.op)
                OP_FMUL_WB:
                begin
                    wr_dst = cmd.dst;
                    wr_data = fmul_res;
                end
                OP_ADD:
                begin
                    wr_dst = cmd.dst;
                    wr_data = sat64(64'(opa) + 64'(opb));
                end
                OP_SUB:
                begin
                    wr_dst = cmd.dst;
                    wr_data = sat64(64'(opa) - 64'(opb));
                end
                default:
                    wr_dst = DST_NONE;
            endcase
        end
    end

    assign xl = $signed({1'b0, cfg_reg[CFG_POS_LIMIT]});
    assign al = $signed({1'b0, cfg_reg[CFG_ANG_LIMIT]});
    assign count_next = (count_reg < STEP_CAP) ? count_reg + 1'b1 : count_reg;
    assign term = (x_reg < -xl) || (x_reg > xl) || (a_reg < -al) || (a_reg > al);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
                cfg_reg[i] <= CFG_RESET[i];
            x_reg <= '0;
            v_reg <= '0;
            a_reg <= '0;
            w_reg <= '0;
            count_reg <= '0;
            fall_reg <= FALL_UPRIGHT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg[cfg_index] <= cfg_data;

            case (wr_dst)
                DST_X:   x_reg <= wr_data;
                DST_V:   v_reg <= wr_data;
                DST_A:   a_reg <= wr_data;
                DST_W:   w_reg <= wr_data;
                default: ;
            endcase

            if (cmd.op == OP_LOAD)
            begin
                x_reg <= ld_x_reg;
                v_reg <= ld_v_reg;
                a_reg <= ld_a_reg;
                w_reg <= ld_w_reg;
                count_reg <= '0;
                fall_reg <= FALL_UPRIGHT;
            end

            if (cmd.op == OP_FIN_STEP || cmd.op == OP_FIN_LOAD)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.op == OP_FIN_STEP)
            begin
                count_reg <= count_next;
                if (term)
                    fall_reg <= (fall_reg == FALL_UPRIGHT) ? FALL_REPORTED : FALL_AFTER;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            push_reg <= push_right;
            ld_x_reg <= load_position;
            ld_v_reg <= load_velocity;
            ld_a_reg <= load_angle;
            ld_w_reg <= load_angular_rate;
        end

        if (cmd.op == OP_MUL)
            prod_reg <= opa * opb;

        if (cmd.op == OP_ANG_IDX)
            idx_reg <= ang_sum[SH+ATB+1:SH];

        if (cmd.op == OP_DIV)
            div_dst_reg <= cmd.dst;

        if (cmd.op == OP_SC_WB)
        begin
            case (idx_reg[ATB+1:ATB])
                2'd0:
                begin
                    s_reg <= smag;
                    c_reg <= cmag;
                end
                2'd1:
                begin
                    s_reg <= cmag;
                    c_reg <= -smag;
                end
                2'd2:
                begin
                    s_reg <= -smag;
                    c_reg <= -cmag;
                end
                default:
                begin
                    s_reg <= -cmag;
                    c_reg <= smag;
                end
            endcase
        end

        case (wr_dst)
            DST_TOT:  tot_reg <= wr_data;
            DST_PML:  pml_reg <= wr_data;
            DST_TEMP: temp_reg <= wr_data;
            DST_DEN:  den_reg <= wr_data;
            DST_TACC: tacc_reg <= wr_data;
            DST_XACC: xacc_reg <= wr_data;
            DST_T1:   t1_reg <= wr_data;
            DST_T2:   t2_reg <= wr_data;
            default:  ;
        endcase

        if (cmd.op == OP_FIN_STEP)
        begin
            out_x_reg <= x_reg;
            out_v_reg <= v_reg;
            out_a_reg <= a_reg;
            out_w_reg <= w_reg;
            out_term_reg <= term;
            out_trunc_reg <= (count_next >= STEP_CAP);
            out_reward_reg <= !term || (fall_reg == FALL_UPRIGHT);
            out_after_reg <= term && (fall_reg != FALL_UPRIGHT);
        end
        else if (cmd.op == OP_FIN_LOAD)
        begin
            out_x_reg <= x_reg;
            out_v_reg <= v_reg;
            out_a_reg <= a_reg;
            out_w_reg <= w_reg;
            out_term_reg <= 1'b0;
            out_trunc_reg <= 1'b0;
            out_reward_reg <= 1'b0;
            out_after_reg <= 1'b0;
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign cart_position = out_x_reg;
    assign cart_velocity = out_v_reg;
    assign pole_angle = out_a_reg;
    assign pole_angular_rate = out_w_reg;
    assign reward = out_reward_reg;
    assign terminated = out_term_reg;
    assign truncated = out_trunc_reg;
    assign after_fall = out_after_reg;

endmodule

/* src/cpps_checker.sv */
// cpps_checker: port-level assertions for cart_pole_physics_step, with the
// bind that attaches them. Depends on cart_pole_physics_step.
module cpps_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [31:0] cart_position,
    input logic reward,
    input logic terminated,
    input logic after_fall
);

    // a step after a reported fall never earns a reward
    a_after_no_reward: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && after_fall |-> !reward)
        else $error("after_fall with reward set");

    a_after_is_term: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && after_fall |-> terminated)
        else $error("after_fall without termination");

    // the first fall of an episode is still rewarded
    a_first_fall_reward: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && terminated && !after_fall |-> reward)
        else $error("first fall without reward");

    // one request at a time: busy straight after acceptance
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cart_position))
        else $error("result dropped while stalled");

endmodule

bind cart_pole_physics_step cpps_checker u_cpps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .cart_position (out_ch.cart_position),
    .reward        (out_ch.reward),
    .terminated    (out_ch.terminated),
    .after_fall    (out_ch.after_fall)
);
